@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the display frame encoder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(LBL, CLK_S, RST_S, ANTE, CONS) \
  LBL: assert property (@(posedge CLK_S) disable iff (RST_S) (ANTE) |-> (CONS)) \
    else $error("assertion %m failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(LBL, CLK_S, RST_S, ANTE, CONS) \
  LBL: assert property (@(posedge CLK_S) disable iff (RST_S) (ANTE) |=> (CONS)) \
    else $error("assertion %m failed");

`endif

@@ design/ssdfe_pkg.sv @@
// ---------------------------------------------------------------------------
// ssdfe_pkg
// Widths, codes, glyph table and shared types of the seven-segment frame
// encoder.
// ---------------------------------------------------------------------------
`default_nettype none

package ssdfe_pkg;

  // Field widths
  localparam int CMD_W     = 2;
  localparam int CHIP_W    = 2;
  localparam int POS_W     = 4;
  localparam int VALUE_W   = 16;
  localparam int POINT_W   = 3;
  localparam int SEG_W     = 8;
  localparam int ADDR_W    = 4;
  localparam int WORD_W    = 16;
  localparam int REM_W     = 14;
  localparam int RECIP_W   = 17;
  localparam int PROD_W    = VALUE_W + RECIP_W;
  localparam int QUO_W     = 10;
  localparam int CNT_W     = 3;
  localparam int IDX_W     = 2;

  // Chain geometry
  localparam int CHAIN_CHIPS_DEF = 3;
  localparam int DIGITS_PER_CHIP = 8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_DECIMAL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HEX     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GEAR    = 2'd2;

  // Special glyphs
  localparam logic [SEG_W-1:0] POINT_BIT  = 8'h80;
  localparam logic [SEG_W-1:0] GLYPH_DASH = 8'h01;
  localparam logic [SEG_W-1:0] GLYPH_P    = 8'h67;

  // Reciprocals for exact division of a 16-bit value
  localparam logic [RECIP_W-1:0] RECIP_10K = 17'd107375;
  localparam int                 SHIFT_10K = 30;
  localparam logic [RECIP_W-1:0] RECIP_100 = 17'd83887;
  localparam int                 SHIFT_100 = 23;

  // Decimal power index of the leading digit
  localparam logic [IDX_W-1:0] POW_THOUSANDS = 2'd3;
  localparam logic [IDX_W-1:0] POW_TENS      = 2'd1;

  // Request as captured from the input channel
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [CHIP_W-1:0]  target_chip;
    logic [POS_W-1:0]   first_position;
    logic               four_digits;
    logic [VALUE_W-1:0] value;
    logic [POINT_W-1:0] point_place;
    logic               kd_flag;
  } req_t;

  // One burst of frames handed to the emitter
  typedef struct packed {
    logic                  decimal;
    logic [REM_W-1:0]      rem;
    logic [IDX_W-1:0]      pow_idx;
    logic [1:0][SEG_W-1:0] fixed_segs;
    logic [POINT_W-1:0]    point;
    logic [CNT_W-1:0]      count;
    logic [POS_W-1:0]      first_pos;
    logic [CHIP_W-1:0]     chip;
  } burst_t;

  // Segment glyphs 0-9, then F, A/R, H/N, P, dash, E
  function automatic logic [SEG_W-1:0] glyph(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:  s = 8'h7e;
      4'd1:  s = 8'h30;
      4'd2:  s = 8'h6d;
      4'd3:  s = 8'h79;
      4'd4:  s = 8'h33;
      4'd5:  s = 8'h5b;
      4'd6:  s = 8'h5f;
      4'd7:  s = 8'h70;
      4'd8:  s = 8'h7f;
      4'd9:  s = 8'h7b;
      4'd10: s = 8'h47;
      4'd11: s = 8'h77;
      4'd12: s = 8'h37;
      4'd13: s = 8'h67;
      4'd14: s = 8'h01;
      4'd15: s = 8'h4f;
    endcase
    return s;
  endfunction

  // k times the decimal power picked by p (k is a loop constant)
  function automatic logic [REM_W-1:0] pow_mult(input logic [IDX_W-1:0] p, input int k);
    logic [REM_W-1:0] m;
    unique case (p)
      2'd3: m = REM_W'(k * 1000);
      2'd2: m = REM_W'(k * 100);
      2'd1: m = REM_W'(k * 10);
      2'd0: m = REM_W'(k);
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ design/ssdfe_if.sv @@
// ---------------------------------------------------------------------------
// ssdfe_if
// Valid/ready channels of the encoder: display requests in, chain frames out.
// ---------------------------------------------------------------------------
`default_nettype none

interface ssdfe_req_if;
  import ssdfe_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [CHIP_W-1:0]  target_chip;
  logic [POS_W-1:0]   first_position;
  logic               four_digits;
  logic [VALUE_W-1:0] value;
  logic [POINT_W-1:0] point_place;
  logic               kd_flag;

  modport source (
    output valid, command, target_chip, first_position, four_digits, value,
           point_place, kd_flag,
    input  ready
  );
  modport sink (
    input  valid, command, target_chip, first_position, four_digits, value,
           point_place, kd_flag,
    output ready
  );
endinterface

interface ssdfe_frame_if #(
  parameter int FRAME_W = ssdfe_pkg::WORD_W * ssdfe_pkg::CHAIN_CHIPS_DEF
);
  import ssdfe_pkg::*;

  logic              valid;
  logic              ready;
  logic [FRAME_W-1:0] frame;
  logic [ADDR_W-1:0] digit_address;
  logic [SEG_W-1:0]  segments;
  logic              last;

  modport source (output valid, frame, digit_address, segments, last, input ready);
  modport sink   (input valid, frame, digit_address, segments, last, output ready);
endinterface

`default_nettype wire

@@ design/ssdfe_emit.sv @@
// ---------------------------------------------------------------------------
// ssdfe_emit
// Frame emitter: walks one burst into an output register, one digit per cycle
// unless the output stalls. Decimal digits are peeled off the remainder most
// significant first; hex and gear glyphs come prebuilt.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ssdfe_emit #(
  parameter int CHAIN_CHIPS = ssdfe_pkg::CHAIN_CHIPS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load_valid,
  input  wire ssdfe_pkg::burst_t load,
  output logic                   load_ready,
  ssdfe_frame_if.source          frames
);
  import ssdfe_pkg::*;

  localparam int FRAME_W = WORD_W * CHAIN_CHIPS;

  // Burst in progress
  logic             busy;
  burst_t           cur;
  logic [IDX_W-1:0] idx;

  // Output register
  logic               out_valid;
  logic [FRAME_W-1:0] out_frame;
  logic [ADDR_W-1:0]  out_addr;
  logic [SEG_W-1:0]   out_seg;
  logic               out_last;

  logic               adv;
  logic               fin;
  logic [3:0]         digit;
  logic [REM_W-1:0]   sub;
  logic [SEG_W-1:0]   seg_next;
  logic [ADDR_W-1:0]  addr_next;
  logic [FRAME_W-1:0] frame_next;

  assign adv        = busy && (!out_valid || frames.ready);
  assign fin        = adv && (CNT_W'(idx) == cur.count - CNT_W'(1));
  assign load_ready = !busy || fin;

  // Leading decimal digit: largest multiple of the current power that fits
  always_comb begin
    digit = 4'd0;
    sub   = '0;
    for (int k = 1; k < 10; k++) begin
      if (cur.rem >= pow_mult(cur.pow_idx, k)) begin
        digit = 4'(k);
        sub   = pow_mult(cur.pow_idx, k);
      end
    end
  end

  // Segment byte, register address and chain frame for this digit
  always_comb begin
    if (cur.decimal) begin
      seg_next = glyph(digit);
      if (cur.point == POINT_W'(cur.pow_idx) + POINT_W'(1)) begin
        seg_next = seg_next | POINT_BIT;
      end
    end else begin
      seg_next = cur.fixed_segs[idx[0]];
    end
    addr_next = cur.first_pos + ADDR_W'(idx);
    for (int c = 0; c < CHAIN_CHIPS; c++) begin
      if (int'(cur.chip) == c + 1) begin
        frame_next[c*WORD_W +: WORD_W] = {{(WORD_W-ADDR_W-SEG_W){1'b0}}, addr_next, seg_next};
      end else begin
        frame_next[c*WORD_W +: WORD_W] = '0;
      end
    end
  end

  // Burst control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load_valid && load_ready) begin
      busy <= 1'b1;
    end else if (fin) begin
      busy <= 1'b0;
    end
  end

  // Burst payload: load, or step to the next digit
  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      cur <= load;
      idx <= '0;
    end else if (adv) begin
      cur.rem     <= cur.rem - sub;
      cur.pow_idx <= cur.pow_idx - IDX_W'(1);
      idx         <= idx + IDX_W'(1);
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (frames.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_frame <= frame_next;
      out_addr  <= addr_next;
      out_seg   <= seg_next;
      out_last  <= fin;
    end
  end

  assign frames.valid         = out_valid;
  assign frames.frame         = out_frame;
  assign frames.digit_address = out_addr;
  assign frames.segments      = out_seg;
  assign frames.last          = out_last;

  // A frame without last means the burst still has frames to give
  `ASSERT_IMPL(a_more_pending, clk, rst, out_valid && !out_last, busy)
  // Finishing a burst with nothing to load leaves the emitter idle
  `ASSERT_NEXT(a_idle_after_fin, clk, rst, fin && !load_valid, !busy)
  // Addresses never run past the chip's digit registers
  `ASSERT_IMPL(a_addr_range, clk, rst, out_valid,
               (out_addr != '0) && (int'(out_addr) <= DIGITS_PER_CHIP))

endmodule

`default_nettype wire

@@ design/seven_segment_digit_frame_encoder.sv @@
// Path: an accepted request goes through the input register, the divide stage,
//   the burst load and the output register before its first frame is valid.
// Throughput: one frame per cycle unless the output stalls; a request gives up
//   to 4 frames, and a request that gives no frame never loads the emitter.
// Reset: synchronous, clears all valid flags and the burst; no memory to clear.
// ---------------------------------------------------------------------------
// seven_segment_digit_frame_encoder
// Turns display requests (decimal, hex, gear) into 48-bit daisy-chain frames
// for a chain of segment-driver chips, one frame per digit register written.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module seven_segment_digit_frame_encoder #(
  parameter int CHAIN_CHIPS = ssdfe_pkg::CHAIN_CHIPS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  ssdfe_req_if.sink     req,
  ssdfe_frame_if.source frames
);
  import ssdfe_pkg::*;

  // Input register
  logic s1_valid;
  req_t s1;

  // Divide stage: request plus reciprocal product
  logic              s2_valid;
  req_t              s2;
  logic [PROD_W-1:0] s2_prod;

  logic              s1_move;
  logic              s2_take;
  logic              s2_free;

  logic [VALUE_W-1:0] rem_full;
  logic               chip_ok;
  logic               pos_ok;
  logic               cmd_ok;
  logic [CNT_W-1:0]   n_digits;
  logic [ADDR_W-1:0]  avail;
  logic [3:0]         lo_nib;
  logic [3:0]         hi_nib;
  burst_t             burst;
  logic               load_valid;
  logic               load_ready;

  // Pipeline flow: a request with no frames leaves stage two at once
  assign s2_take   = s2_valid && (load_ready || burst.count == '0);
  assign s2_free   = !s2_valid || s2_take;
  assign s1_move   = s1_valid && s2_free;
  assign req.ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1.command        <= req.command;
      s1.target_chip    <= req.target_chip;
      s1.first_position <= req.first_position;
      s1.four_digits    <= req.four_digits;
      s1.value          <= req.value;
      s1.point_place    <= req.point_place;
      s1.kd_flag        <= req.kd_flag;
    end
  end

  // Reciprocal multiply for value / 10000 or value / 100
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2      <= s1;
      s2_prod <= PROD_W'(s1.value) * PROD_W'(s1.four_digits ? RECIP_10K : RECIP_100);
    end
  end

  // Remainder: value mod 10000 or value mod 100
  always_comb begin
    if (s2.four_digits) begin
      rem_full = s2.value - VALUE_W'(3'(s2_prod >> SHIFT_10K)) * VALUE_W'(10000);
    end else begin
      rem_full = s2.value - VALUE_W'(QUO_W'(s2_prod >> SHIFT_100)) * VALUE_W'(100);
    end
  end

  // Request checks and frame count
  assign lo_nib   = s2.value[3:0];
  assign hi_nib   = s2.value[7:4];
  assign chip_ok  = (s2.target_chip != '0) && (int'(s2.target_chip) <= CHAIN_CHIPS);
  assign pos_ok   = (s2.first_position != '0) &&
                    (int'(s2.first_position) <= DIGITS_PER_CHIP);
  assign avail    = ADDR_W'(DIGITS_PER_CHIP) - s2.first_position + ADDR_W'(1);
  assign n_digits = (s2.command == CMD_DECIMAL && s2.four_digits) ? CNT_W'(4) : CNT_W'(2);

  always_comb begin
    cmd_ok = 1'b0;
    if (s2.command == CMD_DECIMAL || s2.command == CMD_HEX) begin
      cmd_ok = 1'b1;
    end else if (s2.command == CMD_GEAR) begin
      cmd_ok = s2.kd_flag || (hi_nib <= 4'd2);
    end
  end

  // Burst descriptor for the emitter
  always_comb begin
    burst.decimal   = (s2.command == CMD_DECIMAL);
    burst.rem       = REM_W'(rem_full);
    burst.pow_idx   = s2.four_digits ? POW_THOUSANDS : POW_TENS;
    burst.point     = s2.point_place;
    burst.first_pos = s2.first_position;
    burst.chip      = s2.target_chip;
    if (!(chip_ok && pos_ok && cmd_ok)) begin
      burst.count = '0;
    end else if (avail <= ADDR_W'(n_digits)) begin
      burst.count = CNT_W'(avail);
    end else begin
      burst.count = n_digits;
    end
    if (s2.command == CMD_HEX) begin
      burst.fixed_segs[0] = glyph(lo_nib);
      burst.fixed_segs[1] = glyph(hi_nib);
    end else if (s2.kd_flag) begin
      burst.fixed_segs[0] = GLYPH_DASH;
      burst.fixed_segs[1] = GLYPH_DASH;
    end else begin
      burst.fixed_segs[0] = glyph(4'(4'd10 + hi_nib));
      burst.fixed_segs[1] = (lo_nib != '0) ? glyph(lo_nib) : GLYPH_P;
    end
  end

  assign load_valid = s2_valid && (burst.count != '0);

  ssdfe_emit #(
    .CHAIN_CHIPS(CHAIN_CHIPS)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .load_valid (load_valid),
    .load       (burst),
    .load_ready (load_ready),
    .frames     (frames)
  );

  // Reciprocal divide leaves a remainder below the divisor
  `ASSERT_IMPL(a_rem_bound, clk, rst, s2_valid && s2.command == CMD_DECIMAL,
               s2.four_digits ? (rem_full < 16'd10000) : (rem_full < 16'd100))
  // A loaded burst stays within the chip's digit registers
  `ASSERT_IMPL(a_burst_fits, clk, rst, load_valid,
               int'(burst.first_pos) + int'(burst.count) - 1 <= DIGITS_PER_CHIP)

endmodule

`default_nettype wire
